// ===== rtl/expo_curve_interpolator_defines.svh =====
// Assertion macros shared by the curve interpolator checkers.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef EXPO_CURVE_INTERPOLATOR_DEFINES_SVH
`define EXPO_CURVE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, off during reset.
`define ECI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication, delay given by dly, off during reset.
`define ECI_ASSERT_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== rtl/eci_pkg.sv =====
// Types and constants of the curve interpolator.
// No dependencies; used by every module of the block but eci_ram.
package eci_pkg;

    localparam int unsigned MAX_POINTS_DEF = 64;
    localparam int unsigned LATENCY        = 11;

    localparam logic [1:0] CFG_INPUT_OFFSET = 2'd0;
    localparam logic [1:0] CFG_INPUT_SCALE  = 2'd1;
    localparam logic [1:0] CFG_POINT_COUNT  = 2'd2;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    localparam logic [31:0] SCALE_RESET = 32'h0100_0000;
    localparam int unsigned TERM_W      = 41;
    localparam logic [TERM_W-1:0] TERM_CAP = 41'h100_0000_0000;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] scale;
        logic [6:0]  seg_max;
        logic        straight;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic        straight;
        logic [63:0] m;
    } t_seg_word;

endpackage

// ===== rtl/expo_curve_interpolator.sv =====
// Curve interpolator top: one word per cycle, result strobe o_valid from the last stage.
// The pipeline has eleven register stages: add, abs, scale multiply, RAM read,
// slope, abs, split multiply, cap, add, negate, saturate. Table writes land at RAM read.
// Synchronous reset restores register defaults and drops words in flight; o_busy is
// high only while reset is held. Table contents are kept across reset.
// Depends on eci_pkg, eci_cfg, eci_front, eci_ram, eci_interp.
module expo_curve_interpolator #(
    parameter int unsigned MAX_POINTS = eci_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_kind,
    input  logic signed [31:0] i_sample,
    input  logic [5:0]         i_point_index,
    input  logic signed [31:0] i_point_value,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_curve_value,
    output logic               o_clipped
);

    localparam int unsigned AW = $clog2(MAX_POINTS);

    eci_pkg::t_cfg      cfg;
    eci_pkg::t_seg_word seg_word;
    logic               accept;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr_a;
    logic [AW-1:0]      ram_raddr_b;
    logic [31:0]        ram_rdata_a;
    logic [31:0]        ram_rdata_b;

    assign o_busy = !i_rst_n;
    assign accept = i_start && !o_busy;

    eci_cfg #(
        .MAX_POINTS (MAX_POINTS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    eci_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (accept),
        .i_kind        (i_kind),
        .i_sample      (i_sample),
        .i_point_index (i_point_index),
        .i_point_value (i_point_value),
        .i_cfg         (cfg),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr_a (ram_raddr_a),
        .o_ram_raddr_b (ram_raddr_b),
        .o_seg         (seg_word)
    );

    eci_ram #(
        .WIDTH (32),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    eci_interp u_interp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seg         (seg_word),
        .i_rd_a        (ram_rdata_a),
        .i_rd_b        (ram_rdata_b),
        .o_valid       (o_valid),
        .o_curve_value (o_curve_value),
        .o_clipped     (o_clipped)
    );

endmodule

// ===== rtl/eci_cfg.sv =====
// Configuration registers of the curve interpolator.
// Depends on eci_pkg; point count is clamped and reduced to a segment limit here.
module eci_cfg #(
    parameter int unsigned MAX_POINTS = eci_pkg::MAX_POINTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output eci_pkg::t_cfg o_cfg
);

    logic [31:0] r_offset;
    logic [31:0] r_scale;
    logic [6:0]  r_seg_max;
    logic        r_straight;
    logic [6:0]  count_raw;
    logic [6:0]  count_eff;

    always_comb begin
        count_raw = i_cfg_data[6:0];
        if (count_raw == 7'd0) begin
            count_eff = 7'd1;
        end else if ({25'd0, count_raw} > 32'(MAX_POINTS)) begin
            count_eff = 7'(MAX_POINTS);
        end else begin
            count_eff = count_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= 32'd0;
            r_scale    <= eci_pkg::SCALE_RESET;
            r_seg_max  <= 7'd0;
            r_straight <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                eci_pkg::CFG_INPUT_OFFSET: r_offset <= i_cfg_data;
                eci_pkg::CFG_INPUT_SCALE:  r_scale  <= i_cfg_data;
                eci_pkg::CFG_POINT_COUNT: begin
                    r_seg_max  <= count_eff - 7'd2;
                    r_straight <= (count_eff == 7'd1);
                end
                default: ;
            endcase
        end
    end

    assign o_cfg.offset   = r_offset;
    assign o_cfg.scale    = r_scale;
    assign o_cfg.seg_max  = r_seg_max;
    assign o_cfg.straight = r_straight;

endmodule

// ===== rtl/eci_ram.sv =====
// Generic RAM: one write port, two registered read ports, no reset.
// No dependencies.
module eci_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/eci_front.sv =====
// Front pipeline: offset add, magnitude, scale multiply, segment select.
// Depends on eci_pkg; drives the point RAM's write port and both read addresses.
module eci_front #(
    parameter int unsigned MAX_POINTS = eci_pkg::MAX_POINTS_DEF,
    localparam int unsigned AW        = $clog2(MAX_POINTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_kind,
    input  logic signed [31:0] i_sample,
    input  logic [5:0]         i_point_index,
    input  logic signed [31:0] i_point_value,
    input  eci_pkg::t_cfg      i_cfg,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output logic [31:0]        o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr_a,
    output logic [AW-1:0]      o_ram_raddr_b,
    output eci_pkg::t_seg_word o_seg
);

    logic        r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic        r_a_kind, r_b_kind, r_c_kind;
    logic [5:0]  r_a_idx, r_b_idx, r_c_idx;
    logic [31:0] r_a_val, r_b_val, r_c_val;
    logic [32:0] r_a_sum;
    logic [32:0] r_b_mag;
    logic        r_b_neg, r_c_neg, r_d_neg;
    logic [63:0] r_c_pos;
    logic        r_d_straight;
    logic [63:0] r_d_m;

    logic [32:0]   n_a_sum;
    logic [32:0]   n_b_mag;
    logic [64:0]   prod;
    logic [39:0]   seg_raw;
    logic          clamp;
    logic [AW-1:0] seg;
    logic [39:0]   frac_hi;
    logic [63:0]   n_d_m;

    assign n_a_sum = {i_sample[31], i_sample} + {i_cfg.offset[31], i_cfg.offset};
    assign n_b_mag = r_a_sum[32] ? (~r_a_sum + 33'd1) : r_a_sum;
    assign prod    = 65'(r_b_mag) * 65'(i_cfg.scale);

    always_comb begin
        seg_raw = r_c_pos[63:24];
        clamp   = seg_raw > 40'(i_cfg.seg_max);
        seg     = clamp ? AW'(i_cfg.seg_max) : seg_raw[AW-1:0];
        frac_hi = clamp ? (seg_raw - 40'(i_cfg.seg_max)) : 40'd0;
        n_d_m   = i_cfg.straight ? r_c_pos : {frac_hi, r_c_pos[23:0]};
    end

    assign o_ram_raddr_a = i_cfg.straight ? '0 : seg;
    assign o_ram_raddr_b = seg + AW'(1);
    assign o_ram_we      = r_c_valid && (r_c_kind == eci_pkg::KIND_WRITE)
                           && (32'(r_c_idx) < 32'(MAX_POINTS));
    assign o_ram_waddr   = AW'(r_c_idx);
    assign o_ram_wdata   = r_c_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid && (r_c_kind == eci_pkg::KIND_LOOKUP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_kind     <= i_kind;
        r_a_idx      <= i_point_index;
        r_a_val      <= i_point_value;
        r_a_sum      <= n_a_sum;
        r_b_kind     <= r_a_kind;
        r_b_idx      <= r_a_idx;
        r_b_val      <= r_a_val;
        r_b_neg      <= r_a_sum[32];
        r_b_mag      <= n_b_mag;
        r_c_kind     <= r_b_kind;
        r_c_idx      <= r_b_idx;
        r_c_val      <= r_b_val;
        r_c_neg      <= r_b_neg;
        r_c_pos      <= prod[63:0];
        r_d_neg      <= r_c_neg;
        r_d_straight <= i_cfg.straight;
        r_d_m        <= n_d_m;
    end

    assign o_seg.valid    = r_d_valid;
    assign o_seg.neg      = r_d_neg;
    assign o_seg.straight = r_d_straight;
    assign o_seg.m        = r_d_m;

endmodule

// ===== rtl/eci_interp.sv =====
// Back pipeline: slope, split multiply, term cap, add, sign and saturation.
// Depends on eci_pkg; takes the segment word and both point RAM read words.
module eci_interp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  eci_pkg::t_seg_word i_seg,
    input  logic [31:0]        i_rd_a,
    input  logic [31:0]        i_rd_b,
    output logic               o_valid,
    output logic signed [31:0] o_curve_value,
    output logic               o_clipped
);

    localparam int unsigned TW = eci_pkg::TERM_W;

    logic        r_e_valid, r_f_valid, r_g_valid, r_h_valid;
    logic        r_i_valid, r_j_valid, r_k_valid;
    logic        r_e_neg, r_f_neg, r_g_neg, r_h_neg, r_i_neg;
    logic [63:0] r_e_m, r_f_m;
    logic [31:0] r_e_a, r_f_a, r_g_a, r_h_a;
    logic [32:0] r_e_d;
    logic [32:0] r_f_k;
    logic        r_f_dneg, r_g_dneg, r_h_dneg;
    logic [64:0] r_g_ph, r_g_pl;
    logic [TW-1:0] r_h_t;
    logic [42:0] r_i_v;
    logic [42:0] r_j_w;
    logic [31:0] r_k_value;
    logic        r_k_clip;

    logic [32:0]   n_e_d;
    logic [32:0]   n_f_k;
    logic [41:0]   sum_h;
    logic [TW-1:0] n_h_t;
    logic [42:0]   t_ext;
    logic [42:0]   term;
    logic [42:0]   n_i_v;
    logic [42:0]   n_j_w;
    logic          pos_ovf, neg_ovf;
    logic [31:0]   n_k_value;

    assign n_e_d = i_seg.straight ? {i_rd_a[31], i_rd_a}
                                  : ({i_rd_b[31], i_rd_b} - {i_rd_a[31], i_rd_a});
    assign n_f_k = r_e_d[32] ? (~r_e_d + 33'd1) : r_e_d;

    always_comb begin
        sum_h = 42'({r_g_ph[31:0], 8'd0}) + 42'(r_g_pl[64:24]);
        if ((r_g_ph[64:32] != 33'd0) || (sum_h > 42'(eci_pkg::TERM_CAP))) begin
            n_h_t = eci_pkg::TERM_CAP;
        end else begin
            n_h_t = sum_h[TW-1:0];
        end
    end

    always_comb begin
        t_ext = {2'b00, r_h_t};
        term  = r_h_dneg ? (~t_ext + 43'd1) : t_ext;
        n_i_v = {{11{r_h_a[31]}}, r_h_a} + term;
        n_j_w = r_i_neg ? (~r_i_v + 43'd1) : r_i_v;
    end

    always_comb begin
        pos_ovf = !r_j_w[42] && (r_j_w[41:31] != 11'd0);
        neg_ovf = r_j_w[42] && (r_j_w[41:31] != 11'h7FF);
        if (pos_ovf) begin
            n_k_value = 32'h7FFF_FFFF;
        end else if (neg_ovf) begin
            n_k_value = 32'h8000_0000;
        end else begin
            n_k_value = r_j_w[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
            r_j_valid <= 1'b0;
            r_k_valid <= 1'b0;
        end else begin
            r_e_valid <= i_seg.valid;
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
            r_h_valid <= r_g_valid;
            r_i_valid <= r_h_valid;
            r_j_valid <= r_i_valid;
            r_k_valid <= r_j_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_neg   <= i_seg.neg;
        r_e_m     <= i_seg.m;
        r_e_a     <= i_seg.straight ? 32'd0 : i_rd_a;
        r_e_d     <= n_e_d;
        r_f_neg   <= r_e_neg;
        r_f_m     <= r_e_m;
        r_f_a     <= r_e_a;
        r_f_k     <= n_f_k;
        r_f_dneg  <= r_e_d[32];
        r_g_neg   <= r_f_neg;
        r_g_a     <= r_f_a;
        r_g_dneg  <= r_f_dneg;
        r_g_ph    <= 65'(r_f_m[63:32]) * 65'(r_f_k);
        r_g_pl    <= 65'(r_f_m[31:0]) * 65'(r_f_k);
        r_h_neg   <= r_g_neg;
        r_h_a     <= r_g_a;
        r_h_dneg  <= r_g_dneg;
        r_h_t     <= n_h_t;
        r_i_neg   <= r_h_neg;
        r_i_v     <= n_i_v;
        r_j_w     <= n_j_w;
        r_k_value <= n_k_value;
        r_k_clip  <= pos_ovf || neg_ovf;
    end

    assign o_valid       = r_k_valid;
    assign o_curve_value = r_k_value;
    assign o_clipped     = r_k_clip;

endmodule

// ===== rtl/eci_chk.sv =====
// Port-level checker for the curve interpolator, bound to the top level.
// Depends on eci_pkg and expo_curve_interpolator_defines.svh.
`include "expo_curve_interpolator_defines.svh"

module eci_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               i_kind,
    input logic               o_valid,
    input logic signed [31:0] o_curve_value,
    input logic               o_clipped
);

    localparam int unsigned LAT = eci_pkg::LATENCY;

    logic acc_lookup;
    logic acc_write;

    assign acc_lookup = i_start && !o_busy && (i_kind == eci_pkg::KIND_LOOKUP);
    assign acc_write  = i_start && !o_busy && (i_kind == eci_pkg::KIND_WRITE);

    `ECI_ASSERT_DLY(a_lookup_result, acc_lookup, LAT, o_valid, "lookup word gave no result")
    `ECI_ASSERT_DLY(a_write_silent, acc_write, LAT, !o_valid, "table write gave a result")
    `ECI_ASSERT_IMP(a_result_origin, o_valid, $past(acc_lookup, LAT),
                    "result without a lookup word")
    `ECI_ASSERT_IMP(a_clip_value, o_valid && o_clipped,
                    (o_curve_value == 32'sh7FFF_FFFF) || (o_curve_value == 32'sh8000_0000),
                    "clipped result not at a limit")

endmodule

bind expo_curve_interpolator eci_chk u_chk (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for expo_curve_interpolator: table loads, lookups and register
// phases, each result checked against a local curve predictor. Depends on eci_pkg and the RTL.

typedef struct packed {
    logic signed [31:0] value;
    logic               clipped;
} t_curve_word;

class curve_checker;
    localparam logic [40:0] TERM_LIMIT = 41'h100_0000_0000;

    logic signed [31:0] offset_reg;
    logic [31:0]        scale_reg;
    logic [6:0]         count_reg;
    logic signed [31:0] points [64];
    t_curve_word        pending_curve [$];
    int unsigned        errors;

    function new();
        offset_reg = '0;
        scale_reg  = eci_pkg::SCALE_RESET;
        count_reg  = 7'd1;
        errors     = 0;
        foreach (points[k]) points[k] = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            eci_pkg::CFG_INPUT_OFFSET: offset_reg = data;
            eci_pkg::CFG_INPUT_SCALE:  scale_reg  = data;
            eci_pkg::CFG_POINT_COUNT:  count_reg  = data[6:0];
            default: ;
        endcase
    endfunction

    // (m * k) >> 24, truncated, held at 2^40
    function logic [40:0] scaled_term(logic [63:0] m, logic [32:0] k);
        logic [96:0] prod;
        prod = m * k;
        prod = prod >> 24;
        return (prod > 97'(TERM_LIMIT)) ? TERM_LIMIT : prod[40:0];
    endfunction

    function t_curve_word curve_at(logic signed [31:0] sample);
        longint      sum, val, a, d, c0, tv;
        logic [63:0] magv, pos, seg, frac;
        int unsigned n;
        t_curve_word w;
        sum  = longint'(sample) + longint'(offset_reg);
        magv = (sum < 0) ? -sum : sum;
        pos  = magv * 64'(scale_reg);
        n = count_reg;
        if (n == 0) n = 1;
        if (n > 64) n = 64;
        if (n == 1) begin
            c0 = longint'(points[0]);
            tv = scaled_term(pos, 33'((c0 < 0) ? -c0 : c0));
            val = ((sum < 0) != (c0 < 0)) ? -tv : tv;
        end else begin
            seg = pos >> 24;
            if (seg > 64'(n - 2)) seg = 64'(n - 2);
            frac = pos - (seg << 24);
            a  = longint'(points[seg[5:0]]);
            d  = longint'(points[seg[5:0] + 6'd1]) - a;
            tv = scaled_term(frac, 33'((d < 0) ? -d : d));
            val = a + ((d < 0) ? -tv : tv);
            if (sum < 0) val = -val;
        end
        w.clipped = 1'b1;
        if (val > 64'sd2147483647) begin
            w.value = 32'h7FFF_FFFF;
        end else if (val < -64'sd2147483648) begin
            w.value = 32'h8000_0000;
        end else begin
            w.value   = val[31:0];
            w.clipped = 1'b0;
        end
        return w;
    endfunction

    function void note_word(logic kind, logic signed [31:0] sample, logic [5:0] idx,
                            logic signed [31:0] value);
        if (kind == eci_pkg::KIND_WRITE) points[idx] = value;
        else pending_curve.push_back(curve_at(sample));
    endfunction

    task report(string msg);
        $display("[%0t] curve mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic signed [31:0] value, logic clipped);
        t_curve_word w;
        if (pending_curve.size() == 0) begin
            report($sformatf("unexpected word value=%h clipped=%b", value, clipped));
        end else begin
            w = pending_curve.pop_front();
            if (value !== w.value)
                report($sformatf("curve_value got %h want %h", value, w.value));
            if (clipped !== w.clipped)
                report($sformatf("clipped got %b want %b", clipped, w.clipped));
        end
    endtask

    task flush_leftovers();
        if (pending_curve.size() != 0) begin
            report($sformatf("%0d expected words never arrived", pending_curve.size()));
            pending_curve.delete();
        end
    endtask
endclass

module testbench;
    localparam int unsigned DRAIN_LIMIT = 2000;
    localparam int unsigned PHASES      = 10;
    localparam int unsigned PHASE_ITEMS = 76;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_start       = 1'b0;
    logic               i_kind        = eci_pkg::KIND_LOOKUP;
    logic signed [31:0] i_sample      = '0;
    logic [5:0]         i_point_index = '0;
    logic signed [31:0] i_point_value = '0;
    logic               i_cfg_we      = 1'b0;
    logic [1:0]         i_cfg_index   = eci_pkg::CFG_INPUT_OFFSET;
    logic [31:0]        i_cfg_data    = '0;
    logic               o_busy;
    logic               o_valid;
    logic signed [31:0] o_curve_value;
    logic               o_clipped;

    logic signed [31:0] cur_offset = '0;
    logic [31:0]        cur_scale  = eci_pkg::SCALE_RESET;
    logic [6:0]         cur_count  = 7'd1;

    curve_checker sb;

    expo_curve_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_kind        (i_kind),
        .i_sample      (i_sample),
        .i_point_index (i_point_index),
        .i_point_value (i_point_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_curve_value (o_curve_value),
        .o_clipped     (o_clipped)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy)
            sb.note_word(i_kind, i_sample, i_point_index, i_point_value);
        if (i_rst_n && i_cfg_we)
            sb.set_reg(i_cfg_index, i_cfg_data);
        if (i_rst_n && o_valid)
            sb.check_result(o_curve_value, o_clipped);
    end

    task automatic send_word(logic kind, logic [31:0] sample, logic [5:0] idx,
                             logic [31:0] value);
        i_start       <= 1'b1;
        i_kind        <= kind;
        i_sample      <= sample;
        i_point_index <= idx;
        i_point_value <= value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic lookup(logic [31:0] sample);
        send_word(eci_pkg::KIND_LOOKUP, sample, 6'($urandom), $urandom);
    endtask

    task automatic store(logic [5:0] idx, logic [31:0] value);
        send_word(eci_pkg::KIND_WRITE, $urandom, idx, value);
    endtask

    task automatic idle(int unsigned n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(logic [31:0] offset, logic [31:0] scale, logic [31:0] cdata);
        write_reg(eci_pkg::CFG_INPUT_OFFSET, offset);
        write_reg(eci_pkg::CFG_INPUT_SCALE, scale);
        write_reg(eci_pkg::CFG_POINT_COUNT, cdata);
        cur_offset = offset;
        cur_scale  = scale;
        cur_count  = cdata[6:0];
    endtask

    // wait out every expected word, then the pipeline depth for table writes in flight
    task automatic settle();
        int unsigned waited;
        waited = 0;
        idle(1);
        while (sb.pending_curve.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (eci_pkg::LATENCY + 2) @(posedge i_clk);
        sb.flush_leftovers();
    endtask

    function automatic logic [31:0] rand_point();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        endcase
    endfunction

    // aim most samples at the active table span so every segment gets hit
    function automatic logic [31:0] rand_sample();
        logic [63:0] span;
        longint      target, diff;
        int unsigned n;
        n = cur_count;
        if (n == 0) n = 1;
        if (n > 64) n = 64;
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return -cur_offset;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                span = ((64'(n) + 64'd2) << 24) / ((cur_scale == 0) ? 64'd1 : 64'(cur_scale));
                if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
                target = $urandom_range(0, span[31:0]);
                if ($urandom_range(0, 1)) target = -target;
                diff = target - longint'(cur_offset);
                return diff[31:0];
            end
        endcase
    endfunction

    initial begin
        int unsigned left, blen;
        logic [31:0] offset, scale, cdata;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table before the first lookup
        for (int k = 0; k < 64; k++) store(6'(k), rand_point());

        // straight line at reset settings, extreme point 0
        store(6'd0, 32'h7FFF_FFFF);
        lookup(32'h0000_0000);
        lookup(32'h0000_0001);
        lookup(32'hFFFF_FFFF);
        lookup(32'h7FFF_FFFF);
        lookup(32'h8000_0000);
        store(6'd0, 32'h8000_0000);
        lookup(32'h0000_0001);
        lookup(32'hFFFF_FFFF);
        settle();
        // zero point count, full scale: capped products and a zero sum
        apply_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        lookup(32'h7FFF_FFFF);
        lookup(32'h8000_0001);
        settle();
        // point count above the table size, most negative offset
        apply_config(32'h8000_0000, 32'h0100_0000, 32'hFFFF_FF7F);
        lookup(32'h8000_0000);
        lookup(32'h7FFF_FFFF);
        lookup(32'h4000_0000);
        settle();
        apply_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0002);
        lookup($urandom);
        lookup(32'h8000_0000);
        settle();
        // full table, unit scale: segment ends and extrapolation
        apply_config(32'h0000_0000, 32'h0100_0000, 32'h0000_0040);
        lookup(32'd0);
        lookup(32'd5);
        lookup(32'd62);
        lookup(32'd63);
        lookup(32'd1000);
        lookup(-32'sd7);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            cdata = $urandom;
            case (ph)
                0: cdata[6:0] = 7'd2;
                1: cdata[6:0] = 7'd64;
                2: cdata[6:0] = 7'd0;
                3: cdata[6:0] = 7'd127;
                default: cdata[6:0] = ($urandom_range(0, 3) == 0) ?
                                      7'($urandom_range(0, 127)) : 7'($urandom_range(2, 64));
            endcase
            if (ph == 4) begin
                scale = 32'hFFFF_FFFF;
            end else if (ph == 5) begin
                scale = 32'h0000_0000;
            end else begin
                case ($urandom_range(0, 3))
                    0: scale = 32'h0100_0000;
                    1: scale = $urandom_range(32'h0001_0000, 32'h0400_0000);
                    2: scale = $urandom_range(32'h0000_1000, 32'h0010_0000);
                    default: scale = $urandom;
                endcase
            end
            if (ph == 6) offset = 32'h7FFF_FFFF;
            else if (ph == 7) offset = 32'h8000_0000;
            else if ($urandom_range(0, 4) == 0) offset = $urandom;
            else offset = $urandom_range(0, 2047) - 32'd1024;
            apply_config(offset, scale, cdata);

            left = PHASE_ITEMS;
            while (left > 0) begin
                blen = $urandom_range(1, 24);
                for (int b = 0; b < blen && left > 0; b++) begin
                    if ($urandom_range(0, 6) == 0) store(6'($urandom_range(0, 63)), rand_point());
                    else lookup(rand_sample());
                    left--;
                end
                if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
            end
        end

        settle();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
